// ===== hw/rtl/asbc_pkg.sv =====
// Shared constants, result codes and beat structures for the aligned sparse block compressor.
// Used by asbc_lane, asbc_emit and aligned_sparse_block_compress_w; depends on nothing.
`default_nettype none

package asbc_pkg;

   // Geometry of one source word and of the tile.
   localparam int WORD_ELEMS  = 8;
   localparam int BLOCK_ELEMS = 4;
   localparam int PORTS       = 4;
   localparam int ROWS_MAX    = 64;
   localparam int ELEM_BITS   = 8;
   localparam int NBLK        = WORD_ELEMS / BLOCK_ELEMS;

   // Derived widths.
   localparam int WORD_W     = WORD_ELEMS * ELEM_BITS;
   localparam int BLOCK_W    = BLOCK_ELEMS * ELEM_BITS;
   localparam int SRC_W      = $clog2(2 * WORD_ELEMS);
   localparam int CNT_W      = $clog2(ROWS_MAX + 1);
   localparam int ROW_W      = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;

   // Fixed field widths of the beats.
   localparam int SHIFT_W = 3;
   localparam int KIND_W  = 2;
   localparam int PORT_W  = 2;
   localparam int BLK_W   = 1;
   localparam int SLOT_W  = 6;
   localparam int VAL_W   = 9;

   localparam int REQ_RAW_W  = 2 * WORD_W;
   localparam int REQ_DATA_W = ((REQ_RAW_W + 7) / 8) * 8;
   localparam int RSP_RAW_W  = PORT_W + BLK_W + SLOT_W + VAL_W + WORD_W;
   localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_RAW_W;

   // Result kinds carried on tuser.
   typedef enum logic [KIND_W-1:0] {
      KIND_ROW     = 2'd0,
      KIND_APPEND  = 2'd1,
      KIND_LENGTH  = 2'd2,
      KIND_MAXIMUM = 2'd3
   } kind_type;

   // What one block lane reports for the item being accepted.
   typedef struct packed {
      logic                         app;
      logic [SLOT_W-1:0]            slot;
      logic [PORTS-1:0][CNT_W-1:0]  counts;
   } lane_out_type;

   // One accepted item, as handed to the result sequencer.
   typedef struct packed {
      logic [WORD_W-1:0]                     row;
      logic [PORT_W-1:0]                     port;
      logic [ROW_W-1:0]                      row_idx;
      logic                                  last;
      logic [NBLK-1:0]                       app;
      logic [NBLK-1:0][SLOT_W-1:0]           slot;
      logic [NBLK-1:0][PORTS-1:0][CNT_W-1:0] counts;
   } job_type;

endpackage

`default_nettype wire

// ===== hw/rtl/asbc_lane.sv =====
// One block lane: non-zero detection and the per-port list lengths of one element block.
// Depends on asbc_pkg.
`default_nettype none

module asbc_lane (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic [asbc_pkg::PORT_W-1:0]         port,
   input  wire logic                                last,
   input  wire logic [asbc_pkg::BLOCK_W-1:0]        blk_data,
   output      asbc_pkg::lane_out_type              lane_out
);

   logic [asbc_pkg::PORTS-1:0][asbc_pkg::CNT_W-1:0] cnt_ff;
   logic [asbc_pkg::PORTS-1:0][asbc_pkg::CNT_W-1:0] cnt_in;
   logic [asbc_pkg::PORTS-1:0][asbc_pkg::CNT_W-1:0] cnt_upd;
   logic [asbc_pkg::CNT_W-1:0]                      cur_cnt;
   logic                                            nz;
   logic                                            app;

   // A block is appended when any element is non-zero and the list is not yet full.
   always_comb begin
      nz      = |blk_data;
      cur_cnt = cnt_ff[port];
      app     = nz && (cur_cnt < asbc_pkg::CNT_W'(asbc_pkg::ROWS_MAX));
      for (int p = 0; p < asbc_pkg::PORTS; p++) begin
         cnt_upd[p] = cnt_ff[p] +
                      asbc_pkg::CNT_W'(app && (port == asbc_pkg::PORT_W'(p)));
      end
      cnt_in = last ? '0 : cnt_upd;
   end

   // The lengths after this beat are reported so that the last row can snapshot them.
   always_comb begin
      lane_out.app    = app;
      lane_out.slot   = cur_cnt[asbc_pkg::SLOT_W-1:0];
      lane_out.counts = cnt_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/asbc_emit.sv =====
// Result sequencer: merges the lane findings of one item into result beats, one per free cycle,
// and forms the per-block sums and their maximum while the lengths go out. Depends on asbc_pkg.
`default_nettype none

module asbc_emit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              job_load,
   input  wire asbc_pkg::job_type                 load_job,
   output      logic                              job_ready,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      asbc_pkg::kind_type                rsp_kind,
   output      logic [asbc_pkg::PORT_W-1:0]       rsp_port,
   output      logic [asbc_pkg::BLK_W-1:0]        rsp_blk,
   output      logic [asbc_pkg::SLOT_W-1:0]       rsp_slot,
   output      logic [asbc_pkg::VAL_W-1:0]        rsp_val,
   output      logic [asbc_pkg::WORD_W-1:0]       rsp_row,
   output      logic                              rsp_end
);

   typedef enum logic [3:0] {
      PH_ROW     = 4'b0001,
      PH_APPEND  = 4'b0010,
      PH_LENGTH  = 4'b0100,
      PH_MAXIMUM = 4'b1000
   } phase_type;

   asbc_pkg::job_type                job_ff;
   logic                             job_vld_ff, job_vld_in;
   phase_type                        phase_ff, phase_in;
   logic [asbc_pkg::NBLK-1:0]        pend_ff, pend_in;
   logic [asbc_pkg::PORT_W-1:0]      len_port_ff, len_port_in;
   logic [asbc_pkg::BLK_W-1:0]       len_blk_ff, len_blk_in;
   logic [asbc_pkg::VAL_W-1:0]       sum_ff, sum_in;
   logic [asbc_pkg::VAL_W-1:0]       max_ff, max_in;

   logic                             rsp_vld_ff, rsp_vld_in;
   asbc_pkg::kind_type               kind_ff, kind_in;
   logic [asbc_pkg::PORT_W-1:0]      port_ff, port_in;
   logic [asbc_pkg::BLK_W-1:0]       blk_ff, blk_in;
   logic [asbc_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic [asbc_pkg::VAL_W-1:0]       val_ff, val_in;
   logic [asbc_pkg::WORD_W-1:0]      row_ff, row_in;
   logic                             end_ff, end_in;

   logic                             out_free;
   logic                             finish;
   logic [asbc_pkg::NBLK-1:0]        sel_oh;
   logic [asbc_pkg::NBLK-1:0]        rem;
   logic [asbc_pkg::BLK_W-1:0]       sel_idx;
   logic [asbc_pkg::CNT_W-1:0]       len_cnt;
   logic [asbc_pkg::CNT_W-1:0]       len_one;
   logic [asbc_pkg::VAL_W-1:0]       sum_new;
   logic                             last_port;

   // Next-beat selection: each cycle the output is free, the held item moves one result into it.
   always_comb begin
      out_free    = !rsp_vld_ff || rsp_ready;
      finish      = 1'b0;
      job_vld_in  = job_vld_ff;
      phase_in    = phase_ff;
      pend_in     = pend_ff;
      len_port_in = len_port_ff;
      len_blk_in  = len_blk_ff;
      sum_in      = sum_ff;
      max_in      = max_ff;

      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      kind_in     = kind_ff;
      port_in     = port_ff;
      blk_in      = blk_ff;
      slot_in     = slot_ff;
      val_in      = val_ff;
      row_in      = row_ff;
      end_in      = end_ff;

      sel_oh  = pend_ff & (~pend_ff + 1'b1);
      rem     = pend_ff & ~sel_oh;
      sel_idx = '0;
      for (int b = asbc_pkg::NBLK - 1; b >= 0; b--) begin
         if (pend_ff[b]) begin
            sel_idx = asbc_pkg::BLK_W'(b);
         end
      end

      len_cnt   = job_ff.counts[len_blk_ff][len_port_ff];
      len_one   = (len_cnt == '0) ? asbc_pkg::CNT_W'(1) : len_cnt;
      sum_new   = sum_ff + asbc_pkg::VAL_W'(len_one);
      last_port = (len_port_ff == asbc_pkg::PORT_W'(asbc_pkg::PORTS - 1));

      if (job_vld_ff && out_free) begin
         rsp_vld_in = 1'b1;
         kind_in    = asbc_pkg::KIND_ROW;
         port_in    = job_ff.port;
         blk_in     = '0;
         slot_in    = '0;
         val_in     = '0;
         row_in     = '0;
         end_in     = 1'b0;
         case (phase_ff)
            PH_ROW: begin
               row_in = job_ff.row;
               end_in = (pend_ff == '0) && !job_ff.last;
               if (pend_ff != '0) begin
                  phase_in = PH_APPEND;
               end else if (job_ff.last) begin
                  phase_in = PH_LENGTH;
               end else begin
                  finish = 1'b1;
               end
            end
            PH_APPEND: begin
               kind_in = asbc_pkg::KIND_APPEND;
               blk_in  = sel_idx;
               slot_in = job_ff.slot[sel_idx];
               val_in  = asbc_pkg::VAL_W'(job_ff.row_idx);
               end_in  = (rem == '0) && !job_ff.last;
               pend_in = rem;
               if (rem == '0) begin
                  if (job_ff.last) begin
                     phase_in = PH_LENGTH;
                  end else begin
                     finish = 1'b1;
                  end
               end
            end
            PH_LENGTH: begin
               // Lengths go out block by block; the block sum closes on its last port.
               kind_in = asbc_pkg::KIND_LENGTH;
               port_in = len_port_ff;
               blk_in  = len_blk_ff;
               val_in  = asbc_pkg::VAL_W'(len_cnt);
               if (last_port) begin
                  len_port_in = '0;
                  sum_in      = '0;
                  if (sum_new > max_ff) begin
                     max_in = sum_new;
                  end
                  if (len_blk_ff == asbc_pkg::BLK_W'(asbc_pkg::NBLK - 1)) begin
                     phase_in = PH_MAXIMUM;
                  end else begin
                     len_blk_in = len_blk_ff + 1'b1;
                  end
               end else begin
                  len_port_in = len_port_ff + 1'b1;
                  sum_in      = sum_new;
               end
            end
            PH_MAXIMUM: begin
               kind_in = asbc_pkg::KIND_MAXIMUM;
               port_in = '0;
               val_in  = max_ff;
               end_in  = 1'b1;
               finish  = 1'b1;
            end
            default: begin
               finish = 1'b1;
            end
         endcase
      end

      if (finish) begin
         job_vld_in = 1'b0;
      end
      job_ready = !job_vld_ff || finish;

      // A new item takes the holding register in the cycle the previous one leaves.
      if (job_load) begin
         job_vld_in  = 1'b1;
         phase_in    = PH_ROW;
         pend_in     = load_job.app;
         len_port_in = '0;
         len_blk_in  = '0;
         sum_in      = '0;
         max_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         phase_ff   <= PH_ROW;
      end else begin
         job_vld_ff <= job_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff <= load_job;
      end
      pend_ff     <= pend_in;
      len_port_ff <= len_port_in;
      len_blk_ff  <= len_blk_in;
      sum_ff      <= sum_in;
      max_ff      <= max_in;
      kind_ff     <= kind_in;
      port_ff     <= port_in;
      blk_ff      <= blk_in;
      slot_ff     <= slot_in;
      val_ff      <= val_in;
      row_ff      <= row_in;
      end_ff      <= end_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_port  = port_ff;
   assign rsp_blk   = blk_ff;
   assign rsp_slot  = slot_ff;
   assign rsp_val   = val_ff;
   assign rsp_row   = row_ff;
   assign rsp_end   = end_ff;

   // The maximum always closes the run of its item.
   a_max_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (kind_ff == asbc_pkg::KIND_MAXIMUM) |-> end_ff)
      else $error("maximum beat without run end");

   // Lengths are only sequenced for an item that closes the tile.
   a_length_needs_last: assert property (@(posedge clock) disable iff (reset)
      job_vld_ff && (phase_ff == PH_LENGTH) |-> job_ff.last)
      else $error("length phase on an item without last row");

   // The append phase is never entered with nothing left to append.
   a_append_pending: assert property (@(posedge clock) disable iff (reset)
      job_vld_ff && (phase_ff == PH_APPEND) |-> (pend_ff != '0))
      else $error("append phase with no pending block");

   // Once a run end is taken and no item is held, no stray beat follows.
   a_no_stray_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ready && end_ff && !job_vld_ff |=> !rsp_vld_ff)
      else $error("result beat without an item");

endmodule

`default_nettype wire

// ===== hw/rtl/aligned_sparse_block_compress_w.sv =====
// Top level of the aligned sparse block compressor: realignment, block lanes and sequencer.
// Depends on asbc_pkg, asbc_lane and asbc_emit.
//
// Each request beat carries one port's source word and the word after it, rows in order with
// ports inner. The word is realigned by align_shift elements and sent out first; then, for every
// element block that holds a non-zero element and whose list is not full, an append beat gives
// the row index and the list slot. A beat with tlast also produces all per-port, per-block list
// lengths (block outer, port inner) and the maximum over blocks of the port sums, a zero length
// counting as one; all counters then restart. Results leave through a single output register,
// one beat per cycle while rsp_tready allows; an item gives its row beat and one beat per append,
// and a last item also its length beats and the maximum. A new request is taken in the same cycle
// that the previous item hands over its final result, and while that result still waits in the
// output register. align_shift must be written only while idle; the block does not enforce it.
`default_nettype none

module aligned_sparse_block_compress_w (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Configuration: align_shift.
   input  wire logic                                 csr_wr_en,
   input  wire logic [asbc_pkg::SHIFT_W-1:0]         csr_wr_data,
   // Request beats.
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   input  wire logic [asbc_pkg::REQ_DATA_W-1:0]      req_tdata,  // current_word, following_word
   input  wire logic                                 req_tlast,  // last_row
   // Result beats.
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // port_index, block_index, list_slot, result_value, aligned_row, zero fill
   output      logic [asbc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output      logic [asbc_pkg::KIND_W-1:0]          rsp_tuser,  // result_kind
   output      logic                                 rsp_tlast   // run_end
);

   logic [asbc_pkg::SHIFT_W-1:0]                      shift_ff;
   logic [asbc_pkg::PORT_W-1:0]                       port_ff, port_in;
   logic [asbc_pkg::ROW_W-1:0]                        rowc_ff, rowc_in;
   logic                                              accept;
   logic [asbc_pkg::SRC_W-1:0]                        shamt;
   logic [2*asbc_pkg::WORD_ELEMS-1:0][asbc_pkg::ELEM_BITS-1:0] pair;
   logic [asbc_pkg::WORD_ELEMS-1:0][asbc_pkg::ELEM_BITS-1:0]   aligned;
   asbc_pkg::lane_out_type                            lane_out [asbc_pkg::NBLK];
   asbc_pkg::job_type                                 job;

   asbc_pkg::kind_type                                e_kind;
   logic [asbc_pkg::PORT_W-1:0]                       e_port;
   logic [asbc_pkg::BLK_W-1:0]                        e_blk;
   logic [asbc_pkg::SLOT_W-1:0]                       e_slot;
   logic [asbc_pkg::VAL_W-1:0]                        e_val;
   logic [asbc_pkg::WORD_W-1:0]                       e_row;

   assign accept = req_tvalid && req_tready;

   // Shift register for the realignment offset.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else if (csr_wr_en) begin
         shift_ff <= csr_wr_data;
      end
   end

   // Realignment: element i comes from element i + shift of the two-word window.
   always_comb begin
      pair  = req_tdata[asbc_pkg::REQ_RAW_W-1:0];
      shamt = asbc_pkg::SRC_W'(shift_ff % asbc_pkg::WORD_ELEMS);
      for (int i = 0; i < asbc_pkg::WORD_ELEMS; i++) begin
         aligned[i] = pair[asbc_pkg::SRC_W'(i) + shamt];
      end
   end

   // Port and row position within the tile.
   always_comb begin
      port_in = port_ff;
      rowc_in = rowc_ff;
      if (req_tlast) begin
         port_in = '0;
         rowc_in = '0;
      end else if (port_ff == asbc_pkg::PORT_W'(asbc_pkg::PORTS - 1)) begin
         port_in = '0;
         rowc_in = (rowc_ff == asbc_pkg::ROW_W'(asbc_pkg::ROWS_MAX - 1)) ? '0 : rowc_ff + 1'b1;
      end else begin
         port_in = port_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff <= '0;
         rowc_ff <= '0;
      end else if (accept) begin
         port_ff <= port_in;
         rowc_ff <= rowc_in;
      end
   end

   // One lane per element block.
   for (genvar b = 0; b < asbc_pkg::NBLK; b++) begin : g_lane
      asbc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .accept   (accept),
         .port     (port_ff),
         .last     (req_tlast),
         .blk_data (aligned[b*asbc_pkg::BLOCK_ELEMS +: asbc_pkg::BLOCK_ELEMS]),
         .lane_out (lane_out[b])
      );
   end

   // Gather the lane findings into the item handed to the sequencer.
   always_comb begin
      job.row     = aligned;
      job.port    = port_ff;
      job.row_idx = rowc_ff;
      job.last    = req_tlast;
      for (int b = 0; b < asbc_pkg::NBLK; b++) begin
         job.app[b]    = lane_out[b].app;
         job.slot[b]   = lane_out[b].slot;
         job.counts[b] = lane_out[b].counts;
      end
   end

   asbc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_load  (accept),
      .load_job  (job),
      .job_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (e_kind),
      .rsp_port  (e_port),
      .rsp_blk   (e_blk),
      .rsp_slot  (e_slot),
      .rsp_val   (e_val),
      .rsp_row   (e_row),
      .rsp_end   (rsp_tlast)
   );

   // Result beat packing, first field lowest.
   assign rsp_tdata = {asbc_pkg::RSP_PAD_W'(0), e_row, e_val, e_slot, e_blk, e_port};
   assign rsp_tuser = e_kind;

endmodule

`default_nettype wire

// ===== tb/asbc_result_checker.sv =====
// Result checker for the aligned sparse block compressor: watches the request, result and
// configuration ports, predicts every result beat and compares it field by field.
// Depends on asbc_pkg for geometry, field widths and the result kinds.
`timescale 1ns / 1ps

module asbc_result_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [asbc_pkg::SHIFT_W-1:0]      csr_wr_data,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [asbc_pkg::REQ_DATA_W-1:0]   req_tdata,   // current_word, following_word
   input  wire logic                              req_tlast,   // last_row
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // port_index, block_index, list_slot, result_value, aligned_row, zero fill
   input  wire logic [asbc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic [asbc_pkg::KIND_W-1:0]       rsp_tuser,   // result_kind
   input  wire logic                              rsp_tlast,   // run_end
   output int                                     mismatches,
   output int                                     pending,
   output int                                     beats_checked
);

   // Bit positions of the result fields inside rsp_tdata.
   localparam int BLK_LO  = asbc_pkg::PORT_W;
   localparam int SLOT_LO = BLK_LO + asbc_pkg::BLK_W;
   localparam int VAL_LO  = SLOT_LO + asbc_pkg::SLOT_W;
   localparam int ROW_LO  = VAL_LO + asbc_pkg::VAL_W;

   typedef struct packed {
      asbc_pkg::kind_type                 kind;
      logic [asbc_pkg::PORT_W-1:0]        port;
      logic [asbc_pkg::BLK_W-1:0]         blk;
      logic [asbc_pkg::SLOT_W-1:0]        slot;
      logic [asbc_pkg::VAL_W-1:0]         value;
      logic [asbc_pkg::WORD_W-1:0]        row;
      logic                               run_end;
   } result_beat_type;

   // Predicted state of the block.
   logic [asbc_pkg::SHIFT_W-1:0] align_shift;
   int unsigned                  list_len [asbc_pkg::PORTS][asbc_pkg::NBLK];
   int unsigned                  row_ctr;
   int unsigned                  port_ctr;
   result_beat_type              awaited_results [$];
   int                           mismatch_total;
   int                           checked_total;

   // Realigns one word, appends the row index to each non-zero block's list unless full and, on the
   // last row of a tile, reports every list length and the widest block before clearing.
   task automatic compress_word(input logic [asbc_pkg::WORD_W-1:0] cur,
                                input logic [asbc_pkg::WORD_W-1:0] nxt,
                                input logic last);
      logic [2*asbc_pkg::WORD_W-1:0] pair;
      logic [asbc_pkg::WORD_W-1:0]   aligned;
      int unsigned                   port;
      int unsigned                   sum;
      int unsigned                   widest;
      result_beat_type               beat;
      port    = port_ctr;
      pair    = {nxt, cur};
      aligned = asbc_pkg::WORD_W'(pair >> (int'(align_shift % asbc_pkg::WORD_ELEMS) *
                                           asbc_pkg::ELEM_BITS));
      beat      = '0;
      beat.kind = asbc_pkg::KIND_ROW;
      beat.port = asbc_pkg::PORT_W'(port);
      beat.row  = aligned;
      awaited_results.push_back(beat);
      // One append per block holding a non-zero element, unless its list is full.
      for (int b = 0; b < asbc_pkg::NBLK; b++) begin
         if ((|aligned[b*asbc_pkg::BLOCK_W +: asbc_pkg::BLOCK_W]) &&
             list_len[port][b] < asbc_pkg::ROWS_MAX) begin
            beat       = '0;
            beat.kind  = asbc_pkg::KIND_APPEND;
            beat.port  = asbc_pkg::PORT_W'(port);
            beat.blk   = asbc_pkg::BLK_W'(b);
            beat.slot  = asbc_pkg::SLOT_W'(list_len[port][b]);
            beat.value = asbc_pkg::VAL_W'(row_ctr);
            awaited_results.push_back(beat);
            list_len[port][b]++;
         end
      end
      port_ctr = port + 1;
      if (port_ctr >= asbc_pkg::PORTS) begin
         port_ctr = 0;
         row_ctr  = (row_ctr + 1) % asbc_pkg::ROWS_MAX;
      end
      // Tile end: lengths with block outer and port inner, then the maximum.
      if (last) begin
         widest = 0;
         for (int b = 0; b < asbc_pkg::NBLK; b++) begin
            sum = 0;
            for (int p = 0; p < asbc_pkg::PORTS; p++) begin
               beat       = '0;
               beat.kind  = asbc_pkg::KIND_LENGTH;
               beat.port  = asbc_pkg::PORT_W'(p);
               beat.blk   = asbc_pkg::BLK_W'(b);
               beat.value = asbc_pkg::VAL_W'(list_len[p][b]);
               awaited_results.push_back(beat);
               sum += (list_len[p][b] == 0) ? 1 : list_len[p][b];
               list_len[p][b] = 0;
            end
            if (sum > widest) widest = sum;
         end
         beat       = '0;
         beat.kind  = asbc_pkg::KIND_MAXIMUM;
         beat.value = asbc_pkg::VAL_W'(widest);
         awaited_results.push_back(beat);
         row_ctr  = 0;
         port_ctr = 0;
      end
      // The final beat of this item closes the run.
      beat = awaited_results.pop_back();
      beat.run_end = 1'b1;
      awaited_results.push_back(beat);
   endtask

   task automatic check_field(input string field, input logic [asbc_pkg::WORD_W-1:0] want,
                              input logic [asbc_pkg::WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin
      result_beat_type want;
      if (reset) begin
         align_shift = '0;
         row_ctr     = 0;
         port_ctr    = 0;
         for (int p = 0; p < asbc_pkg::PORTS; p++)
            for (int b = 0; b < asbc_pkg::NBLK; b++)
               list_len[p][b] = 0;
         awaited_results.delete();
         mismatch_total = 0;
         checked_total  = 0;
      end else begin
         // Results are compared before the request of the same edge adds new expectations.
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("result beat with no expectation waiting: kind %0d, data 0x%0h",
                      rsp_tuser, rsp_tdata);
               mismatch_total++;
            end else begin
               want = awaited_results.pop_front();
               check_field("result_kind", want.kind, rsp_tuser);
               check_field("port_index", want.port, rsp_tdata[BLK_LO-1:0]);
               check_field("block_index", want.blk, rsp_tdata[SLOT_LO-1:BLK_LO]);
               check_field("list_slot", want.slot, rsp_tdata[VAL_LO-1:SLOT_LO]);
               check_field("result_value", want.value, rsp_tdata[ROW_LO-1:VAL_LO]);
               check_field("aligned_row", want.row, rsp_tdata[asbc_pkg::RSP_RAW_W-1:ROW_LO]);
               check_field("zero_fill", '0,
                           rsp_tdata[asbc_pkg::RSP_DATA_W-1:asbc_pkg::RSP_RAW_W]);
               check_field("run_end", want.run_end, rsp_tlast);
               checked_total++;
            end
         end
         if (csr_wr_en) align_shift = csr_wr_data;
         if (req_tvalid && req_tready)
            compress_word(req_tdata[asbc_pkg::WORD_W-1:0],
                          req_tdata[2*asbc_pkg::WORD_W-1:asbc_pkg::WORD_W], req_tlast);
      end
      mismatches    <= mismatch_total;
      pending       <= awaited_results.size();
      beats_checked <= checked_total;
   end

endmodule

// ===== tb/tb.sv =====
// Top of the aligned sparse block compressor testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on asbc_pkg, the block and
// asbc_result_checker.
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_ITEMS = 150;
   // Far above any gap a correct run shows from random idling on both sides.
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;

   logic                                  clock       = 1'b0;
   logic                                  reset       = 1'b1;
   logic                                  csr_wr_en   = 1'b0;
   logic [asbc_pkg::SHIFT_W-1:0]          csr_wr_data = '0;
   logic                                  req_tvalid  = 1'b0;
   logic                                  req_tready;
   logic [asbc_pkg::REQ_DATA_W-1:0]       req_tdata   = '0;
   logic                                  req_tlast   = 1'b0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready  = 1'b0;
   logic [asbc_pkg::RSP_DATA_W-1:0]       rsp_tdata;
   logic [asbc_pkg::KIND_W-1:0]           rsp_tuser;
   logic                                  rsp_tlast;

   int  mismatches;
   int  pending;
   int  beats_checked;
   int  items_sent   = 0;
   int  shifts_used  = 0;
   int  stall_cycles = 0;
   bit  no_idle      = 1'b0;

   always #5 clock = ~clock;

   aligned_sparse_block_compress_w i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   asbc_result_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .mismatches    (mismatches),
      .pending       (pending),
      .beats_checked (beats_checked)
   );

   // Result back-pressure: ready drops with a chance of 17 in a hundred unless no_idle is set.
   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 17);
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // Word whose elements are zero with a sparsity chosen afresh for every word.
   function automatic logic [asbc_pkg::WORD_W-1:0] sparse_word();
      logic [asbc_pkg::WORD_W-1:0] w;
      int                          zero_pct;
      zero_pct = $urandom_range(100);
      for (int i = 0; i < asbc_pkg::WORD_ELEMS; i++)
         w[i*asbc_pkg::ELEM_BITS +: asbc_pkg::ELEM_BITS] =
            ($urandom_range(99) < zero_pct) ? '0 :
                                              asbc_pkg::ELEM_BITS'($urandom_range(255));
      return w;
   endfunction

   // Presents one request beat after a random gap and waits for it to be taken.
   task automatic send_word(input logic [asbc_pkg::WORD_W-1:0] cur,
                            input logic [asbc_pkg::WORD_W-1:0] nxt,
                            input logic last);
      while (!no_idle && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {nxt, cur};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Holds requests back until every result has come, then writes the shift.
   task automatic set_shift(input logic [asbc_pkg::SHIFT_W-1:0] shift);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= shift;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shifts_used++;
   endtask

   initial begin
      int random_start;
      int stop_at;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset shift: empty word, full word, each block alone, edge elements of each block.
      send_word('0, '0, 1'b0);
      send_word('1, '0, 1'b0);
      send_word(64'h0000_0000_0000_0001, '1, 1'b0);
      send_word(64'h8000_0000_0000_0000, '1, 1'b0);
      send_word(64'h0000_0000_FF00_0000, '0, 1'b0);
      send_word(64'h0000_0001_0000_0000, '0, 1'b0);
      send_word('0, '1, 1'b0);
      send_word('1, '1, 1'b1);
      // Tiles closed early: after the first port, then part-way through a row.
      send_word('1, '0, 1'b1);
      send_word(64'h0000_00FF_0000_0000, '0, 1'b0);
      send_word('0, '0, 1'b0);
      send_word(64'h0000_0000_0000_00FF, '0, 1'b1);

      // Largest shift: most elements come from the following word.
      set_shift(3'd7);
      send_word('1, '0, 1'b0);
      send_word('0, '1, 1'b0);
      send_word(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1);

      // Half-word shift: each block of the result comes from one source word.
      set_shift(3'd4);
      send_word(64'hFFFF_FFFF_0000_0000, '0, 1'b0);
      send_word('0, 64'h0000_0000_FFFF_FFFF, 1'b0);
      send_word(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 1'b0);
      send_word(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b1);

      set_shift(3'd1);
      send_word(64'h0000_0000_0000_00FF, 64'h0000_0000_0000_0001, 1'b0);
      send_word(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0080, 1'b1);

      // Random tiles of whole rows, some cut short, with the shift changed between tiles.
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 40) set_shift(asbc_pkg::SHIFT_W'($urandom_range(7)));
         stop_at = $urandom_range(1, 6) * asbc_pkg::PORTS - 1;
         if ($urandom_range(99) < 15) stop_at = $urandom_range(stop_at);
         for (int k = 0; k <= stop_at; k++) begin
            no_idle <= (items_sent - random_start >= 60) && (items_sent - random_start < 100);
            send_word(sparse_word(), sparse_word(), k == stop_at);
         end
      end
      no_idle <= 1'b0;

      // Drain: every result in, then a quiet spell to catch anything stray.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats and checked %0d result beats across %0d shift writes,",
               items_sent, beats_checked, shifts_used);
      $display("including early tile ends, shifts up to seven elements and random sparsity.");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
